[design/spi_pkg.sv]
// Shared types, codes and arithmetic helpers of the skeletal pose interpolator.
package spi_pkg;

	localparam int MAX_BONES_DEF = 128;

	// Configuration register indexes
	localparam logic [0:0] CFG_FRAME_COUNT = 1'b0;
	localparam logic [0:0] CFG_FRAME_RATE  = 1'b1;

	// Input function codes
	localparam logic [1:0] FUNC_TICK    = 2'd0;
	localparam logic [1:0] FUNC_BONE    = 2'd1;
	localparam logic [1:0] FUNC_RESTART = 2'd2;
	localparam logic [1:0] FUNC_UNUSED  = 2'd3;

	// Result kinds
	localparam logic KIND_FRAME = 1'b0;
	localparam logic KIND_BONE  = 1'b1;

	localparam logic [8:0]  FRAME_COUNT_RST = 9'd1;
	localparam logic [15:0] FRAME_RATE_RST  = 16'd7680;
	localparam logic [15:0] UNIT_Q13        = 16'h2000;
	localparam logic signed [37:0] ONE_Q28  = 38'sd268435456;

	// Step counts of each sequencer phase
	localparam logic [5:0] N_TICK  = 6'd1;
	localparam logic [5:0] N_BLEND = 6'd7;
	localparam logic [5:0] N_QPROD = 6'd9;
	localparam logic [5:0] N_QMAT  = 6'd1;
	localparam logic [5:0] N_PREAD = 6'd3;
	localparam logic [5:0] N_CAT   = 6'd36;
	localparam logic [5:0] N_STORE = 6'd3;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_RESTART, OP_TICK, OP_BLEND, OP_QPROD,
		OP_QMAT, OP_PREAD, OP_CAT, OP_STORE, OP_EMIT
	} spi_op_t;

	typedef enum logic [3:0] {
		S_IDLE, S_TICK, S_BLEND, S_QPROD, S_QMAT, S_PREAD, S_CAT, S_STORE, S_EMIT
	} spi_state_t;

	typedef struct packed {
		spi_op_t    op;
		logic [5:0] step;
		logic       kind;
	} spi_cmd_t;

	typedef struct packed {
		logic has_parent;
	} spi_stat_t;

	// Pick one signed 16-bit lane of a packed word
	function automatic logic signed [15:0] lane16(input logic [63:0] w, input logic [1:0] k);
		return $signed(w[16*k +: 16]);
	endfunction

	// Round half up (toward plus infinity) while shifting right
	function automatic logic signed [37:0] round_shr(input logic signed [37:0] v,
		input int unsigned sh);
		logic signed [37:0] t;
		t = v + (38'sd1 <<< (sh - 1));
		return t >>> sh;
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [37:0] v);
		if (v > 38'sd32767)
			return 16'sh7fff;
		if (v < -38'sd32768)
			return 16'sh8000;
		return v[15:0];
	endfunction

	// One rotation matrix entry from two quaternion products
	function automatic logic signed [15:0] qm_entry(input logic signed [31:0] a,
		input logic signed [31:0] b, input logic neg_b, input logic diag);
		logic signed [37:0] s;
		logic signed [37:0] raw;
		s = neg_b ? (38'(a) - 38'(b)) : (38'(a) + 38'(b));
		raw = diag ? (ONE_Q28 - (s <<< 1)) : (s <<< 1);
		return sat16(round_shr(raw, 15));
	endfunction

	// Divide a step number below 48 by three
	function automatic logic [3:0] div3(input logic [5:0] s);
		logic [12:0] p;
		p = 13'(s) * 13'd43;
		return p[10:7];
	endfunction

	function automatic logic [63:0] ident_row(input logic [1:0] k);
		return 64'(UNIT_Q13) << (16 * k);
	endfunction

endpackage

[design/skeletal_pose_interpolator_unit.sv]
// Top level of the skeletal pose interpolator: sequencer plus datapath.
//
// Input channel (in_valid/in_stall) carries one item per transfer: a tick
// (func 0) reports frame_now, frame_next and blend_weight at the current
// play position and then advances it; a bone item (func 1) blends two
// keyframe poses with the latched weight, builds the 3x4 transform, applies
// the parent transform if any, stores it and returns it; a restart (func 2)
// zeroes the position and weight and returns nothing.
// Output channel (out_valid/out_stall) holds one result in a register; the
// next item is taken while that result still waits.
// Items are worked one at a time; the 36 products of the parent concatenation
// run on the single shared 18x18 multiplier and make a bone with parent the
// longest item.
// A stalled receiver holds the result; the next result waits in the emit step.
// Reset restores frame_count 1, frame_rate 30.0 and position zero, and marks
// every bone transform as identity through per-bone valid bits (no clearing
// pass). The configuration port is always ready; write it only while idle.
module skeletal_pose_interpolator_unit import spi_pkg::*; #(
	parameter int MAX_BONES = MAX_BONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  func,
	input  logic [15:0] time_step,
	input  logic [6:0]  bone_index,
	input  logic signed [7:0] parent_index,
	input  logic [63:0] rotation_now,
	input  logic [63:0] rotation_next,
	input  logic [47:0] position_now,
	input  logic [47:0] position_next,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        result_kind,
	output logic [7:0]  frame_now,
	output logic [7:0]  frame_next,
	output logic [15:0] blend_weight,
	output logic [6:0]  echo_bone,
	output logic [63:0] matrix_row_x,
	output logic [63:0] matrix_row_y,
	output logic [63:0] matrix_row_z,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	spi_cmd_t  cmd;
	spi_stat_t stat;

	assign cfg_ready = 1'b1;

	spi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.func      (func),
		.stat      (stat),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_stall (out_stall)
	);

	spi_dpath #(.MAX_BONES(MAX_BONES)) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.time_step     (time_step),
		.bone_index    (bone_index),
		.parent_index  (parent_index),
		.rotation_now  (rotation_now),
		.rotation_next (rotation_next),
		.position_now  (position_now),
		.position_next (position_next),
		.result_kind   (result_kind),
		.frame_now     (frame_now),
		.frame_next    (frame_next),
		.blend_weight  (blend_weight),
		.echo_bone     (echo_bone),
		.matrix_row_x  (matrix_row_x),
		.matrix_row_y  (matrix_row_y),
		.matrix_row_z  (matrix_row_z)
	);

endmodule

[design/spi_ctrl.sv]
// Sequencer of the pose interpolator: steps the datapath through each item.
module spi_ctrl import spi_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  logic [1:0] func,
	input  spi_stat_t stat,
	output spi_cmd_t  cmd,
	output logic      out_valid,
	input  logic      out_stall
);

	spi_state_t state_q, state_d, nxt_state;
	logic [5:0] step_q, step_d, last_n;
	logic       kind_q, kind_d;
	logic       out_valid_q, out_valid_d;
	logic       run;
	spi_op_t    run_op;

	// State, step and result-slot registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			kind_q      <= KIND_FRAME;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			kind_q      <= kind_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		kind_d      = kind_q;
		out_valid_d = out_valid_q && out_stall;
		cmd         = '{op: OP_NONE, step: step_q, kind: kind_q};
		run         = 1'b0;
		run_op      = OP_NONE;
		last_n      = '0;
		nxt_state   = S_IDLE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					step_d = '0;
					case (func)
						FUNC_TICK: begin
							cmd.op  = OP_LOAD;
							kind_d  = KIND_FRAME;
							state_d = S_TICK;
						end
						FUNC_BONE: begin
							cmd.op  = OP_LOAD;
							kind_d  = KIND_BONE;
							state_d = S_BLEND;
						end
						FUNC_RESTART: cmd.op = OP_RESTART;
						default: ;
					endcase
				end
			end
			S_TICK: begin
				run = 1'b1; run_op = OP_TICK; last_n = N_TICK; nxt_state = S_EMIT;
			end
			S_BLEND: begin
				run = 1'b1; run_op = OP_BLEND; last_n = N_BLEND; nxt_state = S_QPROD;
			end
			S_QPROD: begin
				run = 1'b1; run_op = OP_QPROD; last_n = N_QPROD; nxt_state = S_QMAT;
			end
			S_QMAT: begin
				run = 1'b1; run_op = OP_QMAT; last_n = N_QMAT;
				nxt_state = stat.has_parent ? S_PREAD : S_STORE;
			end
			S_PREAD: begin
				run = 1'b1; run_op = OP_PREAD; last_n = N_PREAD; nxt_state = S_CAT;
			end
			S_CAT: begin
				run = 1'b1; run_op = OP_CAT; last_n = N_CAT; nxt_state = S_STORE;
			end
			S_STORE: begin
				run = 1'b1; run_op = OP_STORE; last_n = N_STORE; nxt_state = S_EMIT;
			end
			S_EMIT: begin
				// Load the result register once the slot is free
				if (!out_valid_q || !out_stall) begin
					cmd.op      = OP_EMIT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		// Issue the phase steps, then a drain step with no command
		if (run) begin
			if (step_q < last_n)
				cmd.op = run_op;
			if (step_q == last_n) begin
				state_d = nxt_state;
				step_d  = '0;
			end else begin
				step_d = step_q + 6'd1;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result valid rose outside the emit state");
	a_cat_entry: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CAT && $past(state_q) != S_CAT) |-> $past(state_q == S_PREAD))
		else $error("concatenation started without a parent read");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		run |-> step_q <= last_n)
		else $error("step counter ran past its phase");
	a_emit_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && out_stall) |=> state_q == S_EMIT)
		else $error("result overwritten while stalled");
`endif

endmodule

[design/spi_dpath.sv]
// Datapath of the pose interpolator: play position, shared multiplier, bone matrix store.
module spi_dpath import spi_pkg::*; #(
	parameter int MAX_BONES = MAX_BONES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  spi_cmd_t    cmd,
	output spi_stat_t   stat,
	input  logic        cfg_valid,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic [15:0] time_step,
	input  logic [6:0]  bone_index,
	input  logic signed [7:0] parent_index,
	input  logic [63:0] rotation_now,
	input  logic [63:0] rotation_next,
	input  logic [47:0] position_now,
	input  logic [47:0] position_next,
	output logic        result_kind,
	output logic [7:0]  frame_now,
	output logic [7:0]  frame_next,
	output logic [15:0] blend_weight,
	output logic [6:0]  echo_bone,
	output logic [63:0] matrix_row_x,
	output logic [63:0] matrix_row_y,
	output logic [63:0] matrix_row_z
);

	localparam int ROWS = MAX_BONES * 3;
	localparam int AW = $clog2(ROWS);
	localparam int IW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
	localparam logic [8:0] NB = 9'(MAX_BONES);

	// Control and configuration state
	spi_cmd_t    cmd_s1;
	logic [8:0]  cnt_q;
	logic [15:0] rate_q;
	logic [23:0] pos_q;
	logic [15:0] held_q;
	logic [MAX_BONES-1:0] vld_q;

	// Item operands and working values
	logic [15:0] ts_q;
	logic [6:0]  bone_q;
	logic [7:0]  par_q;
	logic [63:0] rn_q, rx_q;
	logic [47:0] pn_q, px_q;
	logic [7:0]  now_q, next_q;
	logic signed [15:0] q_q [4];
	logic signed [15:0] p_q [3];
	logic signed [31:0] pp_q [9];
	logic signed [15:0] r_q [3][3];
	logic signed [15:0] m_q [3][4];
	logic [63:0] pr_q [3];
	logic signed [37:0] acc_q;
	logic signed [35:0] prod_s1;
	logic [63:0] mem [ROWS];
	logic [63:0] rd_q;

	// Combinational signals
	logic [8:0]  cnt_eff;
	logic [24:0] cnt16;
	logic [23:0] pos_eff;
	logic [8:0]  now9;
	logic [24:0] pos_sum;
	logic        has_par, bone_ok;
	logic [7:0]  bone8;
	logic signed [17:0] ma, mb;
	logic signed [15:0] ia, ib, ca;
	logic signed [16:0] diff;
	logic [31:0] bl_sum;
	logic [3:0]  e0, e1;
	logic [1:0]  k0, k1, i0, i1, j0, j1;
	logic signed [37:0] cat_tot, cat_rs;
	logic [9:0]  par3, bone3;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [63:0] wr_data;
	logic signed [15:0] rm [3][3];

	assign cnt_eff = (cnt_q == 9'd0) ? 9'd1 : ((cnt_q > 9'd256) ? 9'd256 : cnt_q);
	assign cnt16   = {cnt_eff, 16'h0};
	assign pos_eff = ({1'b0, pos_q} >= cnt16) ? 24'h0 : pos_q;
	assign now9    = {1'b0, pos_eff[23:16]} + 9'd1;
	assign pos_sum = {1'b0, pos_q} + {1'b0, prod_s1[31:8]};
	assign has_par = !par_q[7] && ({1'b0, par_q} < NB);
	assign bone8   = {1'b0, bone_q};
	assign bone_ok = ({1'b0, bone8} < NB);
	assign stat.has_parent = has_par;

	// Blend lanes: rotation for steps 0..3, position for steps 4..6
	assign ia = cmd.step[2] ? lane16({16'h0, pn_q}, cmd.step[1:0]) : lane16(rn_q, cmd.step[1:0]);
	assign ib = cmd.step[2] ? lane16({16'h0, px_q}, cmd.step[1:0]) : lane16(rx_q, cmd.step[1:0]);
	assign ca = cmd_s1.step[2] ? lane16({16'h0, pn_q}, cmd_s1.step[1:0]) :
		lane16(rn_q, cmd_s1.step[1:0]);
	assign diff = 17'(ib) - 17'(ia);
	assign bl_sum = prod_s1[31:0] + 32'd32768;

	// Concatenation step decode: entry = step / 3, term = step % 3
	assign e0 = div3(cmd.step);
	assign k0 = 2'(cmd.step - 6'(e0) * 6'd3);
	assign i0 = e0[3:2];
	assign j0 = e0[1:0];
	assign e1 = div3(cmd_s1.step);
	assign k1 = 2'(cmd_s1.step - 6'(e1) * 6'd3);
	assign i1 = e1[3:2];
	assign j1 = e1[1:0];
	assign cat_tot = acc_q + 38'(prod_s1);
	assign cat_rs  = round_shr(cat_tot, 13) + ((j1 == 2'd3) ? 38'(lane16(pr_q[i1], 2'd3)) : '0);

	// Memory addresses
	assign par3    = ({2'b0, par_q} << 1) + {2'b0, par_q} + {8'h0, cmd.step[1:0]};
	assign bone3   = ({3'b0, bone_q} << 1) + {3'b0, bone_q} + {8'h0, cmd.step[1:0]};
	assign rd_addr = AW'(par3);
	assign wr_addr = AW'(bone3);
	assign wr_data = {m_q[cmd.step[1:0]][3], m_q[cmd.step[1:0]][2],
		m_q[cmd.step[1:0]][1], m_q[cmd.step[1:0]][0]};

	// Rotation matrix from the blended quaternion
	assign rm[0][0] = qm_entry(pp_q[1], pp_q[2], 1'b0, 1'b1);
	assign rm[0][1] = qm_entry(pp_q[3], pp_q[8], 1'b1, 1'b0);
	assign rm[0][2] = qm_entry(pp_q[4], pp_q[7], 1'b0, 1'b0);
	assign rm[1][0] = qm_entry(pp_q[3], pp_q[8], 1'b0, 1'b0);
	assign rm[1][1] = qm_entry(pp_q[0], pp_q[2], 1'b0, 1'b1);
	assign rm[1][2] = qm_entry(pp_q[5], pp_q[6], 1'b1, 1'b0);
	assign rm[2][0] = qm_entry(pp_q[4], pp_q[7], 1'b1, 1'b0);
	assign rm[2][1] = qm_entry(pp_q[5], pp_q[6], 1'b0, 1'b0);
	assign rm[2][2] = qm_entry(pp_q[0], pp_q[1], 1'b0, 1'b1);

	// Select multiplier operands
	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_TICK: begin
				ma = {2'b0, ts_q};
				mb = {2'b0, rate_q};
			end
			OP_BLEND: begin
				ma = 18'(diff);
				mb = {2'b0, held_q};
			end
			OP_QPROD: begin
				case (cmd.step[3:0])
					4'd0: begin ma = 18'(q_q[0]); mb = 18'(q_q[0]); end
					4'd1: begin ma = 18'(q_q[1]); mb = 18'(q_q[1]); end
					4'd2: begin ma = 18'(q_q[2]); mb = 18'(q_q[2]); end
					4'd3: begin ma = 18'(q_q[0]); mb = 18'(q_q[1]); end
					4'd4: begin ma = 18'(q_q[0]); mb = 18'(q_q[2]); end
					4'd5: begin ma = 18'(q_q[1]); mb = 18'(q_q[2]); end
					4'd6: begin ma = 18'(q_q[3]); mb = 18'(q_q[0]); end
					4'd7: begin ma = 18'(q_q[3]); mb = 18'(q_q[1]); end
					4'd8: begin ma = 18'(q_q[3]); mb = 18'(q_q[2]); end
					default: ;
				endcase
			end
			OP_CAT: begin
				ma = 18'(lane16(pr_q[i0], k0));
				mb = (j0 == 2'd3) ? 18'(p_q[k0]) : 18'(r_q[k0][j0]);
			end
			default: ;
		endcase
	end

	// Control registers: command delay, configuration, position, valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1 <= '{op: OP_NONE, step: '0, kind: KIND_FRAME};
			cnt_q  <= FRAME_COUNT_RST;
			rate_q <= FRAME_RATE_RST;
			pos_q  <= '0;
			held_q <= '0;
			vld_q  <= '0;
		end else begin
			cmd_s1 <= cmd;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_FRAME_COUNT: cnt_q <= cfg_data[8:0];
					CFG_FRAME_RATE:  rate_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.op == OP_RESTART) begin
				pos_q  <= '0;
				held_q <= '0;
			end
			// Wrap a stale position, then latch the weight
			if (cmd.op == OP_TICK) begin
				pos_q  <= pos_eff;
				held_q <= pos_eff[15:0];
			end
			// Advance and wrap at the frame count
			if (cmd_s1.op == OP_TICK)
				pos_q <= (pos_sum >= cnt16) ? 24'h0 : pos_sum[23:0];
			if (cmd.op == OP_STORE && bone_ok)
				vld_q[bone8[IW-1:0]] <= 1'b1;
		end
	end

	// Working registers
	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (cmd.op == OP_LOAD) begin
			ts_q   <= time_step;
			bone_q <= bone_index;
			par_q  <= parent_index;
			rn_q   <= rotation_now;
			rx_q   <= rotation_next;
			pn_q   <= position_now;
			px_q   <= position_next;
		end
		if (cmd.op == OP_TICK) begin
			now_q  <= pos_eff[23:16];
			next_q <= (now9 == cnt_eff) ? 8'h0 : now9[7:0];
		end
		// Finish a blend lane
		if (cmd_s1.op == OP_BLEND) begin
			if (cmd_s1.step[2])
				p_q[cmd_s1.step[1:0]] <= ca + $signed(bl_sum[31:16]);
			else
				q_q[cmd_s1.step[1:0]] <= ca + $signed(bl_sum[31:16]);
		end
		if (cmd_s1.op == OP_QPROD)
			pp_q[cmd_s1.step[3:0]] <= prod_s1[31:0];
		// Build the local matrix
		if (cmd.op == OP_QMAT) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					r_q[i][j] <= rm[i][j];
					m_q[i][j] <= rm[i][j];
				end
				m_q[i][3] <= p_q[i];
			end
		end
		// Take a parent row, identity if never stored
		if (cmd_s1.op == OP_PREAD)
			pr_q[cmd_s1.step[1:0]] <= vld_q[par_q[IW-1:0]] ? rd_q :
				ident_row(cmd_s1.step[1:0]);
		// Accumulate the dot products of the concatenation
		if (cmd_s1.op == OP_CAT) begin
			case (k1)
				2'd0: acc_q <= 38'(prod_s1);
				2'd1: acc_q <= cat_tot;
				default: m_q[i1][j1] <= sat16(cat_rs);
			endcase
		end
		// Load the result register
		if (cmd.op == OP_EMIT) begin
			result_kind <= cmd.kind;
			if (cmd.kind == KIND_FRAME) begin
				frame_now    <= now_q;
				frame_next   <= next_q;
				blend_weight <= held_q;
				echo_bone    <= '0;
				matrix_row_x <= '0;
				matrix_row_y <= '0;
				matrix_row_z <= '0;
			end else begin
				frame_now    <= '0;
				frame_next   <= '0;
				blend_weight <= '0;
				echo_bone    <= bone_q;
				matrix_row_x <= {m_q[0][3], m_q[0][2], m_q[0][1], m_q[0][0]};
				matrix_row_y <= {m_q[1][3], m_q[1][2], m_q[1][1], m_q[1][0]};
				matrix_row_z <= {m_q[2][3], m_q[2][2], m_q[2][1], m_q[2][0]};
			end
		end
	end

	// Bone matrix store, three rows per bone
	always_ff @(posedge clk) begin
		rd_q <= mem[rd_addr];
		if (cmd.op == OP_STORE && bone_ok)
			mem[wr_addr] <= wr_data;
	end

endmodule
